/* hw/rtl/pblw_pkg.sv */
// ----------------------------------------------------------------------------
// pblw_pkg
// Shared widths, reset values and codes of the planar line walker.
// ----------------------------------------------------------------------------
package pblw_pkg;

  localparam int OFF_W  = 22;
  localparam int MASK_W = 8;
  localparam int LB_W   = 11;

  localparam logic [LB_W-1:0]   LB_RESET   = LB_W'(80);
  localparam logic [MASK_W-1:0] MASK_RESET = 8'h80;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_e;

  typedef struct packed {
    logic [OFF_W-1:0]  byte_offset;
    logic [MASK_W-1:0] bit_mask;
    logic              last_pixel;
  } pix_t;

endpackage

/* hw/rtl/pblw_in_if.sv */
// ----------------------------------------------------------------------------
// pblw_in_if
// Command channel: start a line or step one pixel.
// ----------------------------------------------------------------------------
interface pblw_in_if #(
  parameter int COORD_BITS = 11
) ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic        [COORD_BITS-1:0] start_x;
  logic        [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS:0]   delta_x;
  logic signed [COORD_BITS:0]   delta_y;

  modport source (output valid, func, start_x, start_y, delta_x, delta_y, input ready);
  modport sink   (input valid, func, start_x, start_y, delta_x, delta_y, output ready);
endinterface

/* hw/rtl/pblw_out_if.sv */
// ----------------------------------------------------------------------------
// pblw_out_if
// Pixel channel: byte offset, bit mask and last flag per beat.
// ----------------------------------------------------------------------------
interface pblw_out_if import pblw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OFF_W-1:0]  byte_offset;
  logic [MASK_W-1:0] bit_mask;
  logic              last_pixel;

  modport source (output valid, byte_offset, bit_mask, last_pixel, input ready);
  modport sink   (input valid, byte_offset, bit_mask, last_pixel, output ready);
endinterface

/* hw/rtl/pblw_cfg_if.sv */
// ----------------------------------------------------------------------------
// pblw_cfg_if
// Configuration write channel carrying the scan line length in bytes.
// ----------------------------------------------------------------------------
interface pblw_cfg_if import pblw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [LB_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/planar_bresenham_line_walker.sv */
// A step beat's pixel is registered into the output register, or into the skid entry under a stall.
// One beat per cycle while the skid entry is empty; a start beat loads the line into the walker state.
// The start offset y*line_bytes + x/8 is one multiply-add into the walker state.
// A two-entry output (register plus skid) keeps the input open under one stall.
// Reset: asynchronous, active low; idle, line_bytes = 80, no clearing pass.
// ----------------------------------------------------------------------------
// planar_bresenham_line_walker
// Bresenham address engine for a one-bit-per-plane frame buffer.
// ----------------------------------------------------------------------------
module planar_bresenham_line_walker import pblw_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pblw_cfg_if.sink   cfg_i,
  pblw_in_if.sink    in_i,
  pblw_out_if.source out_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int XW = COORD_BITS + 2;
  localparam logic [DW-1:0] DMIN = {1'b1, {COORD_BITS{1'b0}}};

  logic [LB_W-1:0]       lb_q;
  logic                  active_q, active_d;
  logic [OFF_W-1:0]      off_q, off_d;
  logic [MASK_W-1:0]     mask_q, mask_d;
  logic signed [XW-1:0]  dec_q, dec_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [COORD_BITS-1:0] adx_q, adx_d;
  logic [COORD_BITS-1:0] ady_q, ady_d;
  logic                  xmaj_q, xmaj_d;
  logic                  up_q, up_d;

  pix_t out_q, skid_q, pix;
  logic out_v_q, skid_v_q;

  logic acc, push, pop;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !skid_v_q;
  assign acc  = in_i.valid && in_i.ready;
  assign push = acc && (in_i.func == FUNC_STEP) && active_q;
  assign pop  = out_v_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_q <= LB_RESET;
    end else if (cfg_i.valid) begin
      lb_q <= cfg_i.data;
    end
  end

  // ---- start: mirror, absolute extents, start address ----
  logic [DW-1:0]         dxs, dys;
  logic signed [XW-1:0]  x_e, y_e, dx_e, dy_e, x_m, y_m, dy_m;
  logic                  neg_x;
  logic [COORD_BITS-1:0] s_adx, s_ady, s_major;
  logic                  s_up, s_xmaj;
  logic signed [OFF_W-1:0] y_w, lb_w, row_off, col_off;
  logic [OFF_W-1:0]      s_off;
  logic [MASK_W-1:0]     s_mask;

  always_comb begin
    dxs     = (in_i.delta_x == DMIN) ? DMIN + DW'(1) : in_i.delta_x;
    dys     = (in_i.delta_y == DMIN) ? DMIN + DW'(1) : in_i.delta_y;
    neg_x   = dxs[DW-1];
    x_e     = signed'({2'b00, in_i.start_x});
    y_e     = signed'({2'b00, in_i.start_y});
    dx_e    = XW'(signed'(dxs));
    dy_e    = XW'(signed'(dys));
    x_m     = neg_x ? x_e + dx_e : x_e;
    y_m     = neg_x ? y_e + dy_e : y_e;
    dy_m    = neg_x ? -dy_e : dy_e;
    s_adx   = COORD_BITS'(neg_x ? -dx_e : dx_e);
    s_up    = dy_m[XW-1];
    s_ady   = COORD_BITS'(s_up ? -dy_m : dy_m);
    s_xmaj  = s_adx > s_ady;
    s_major = s_xmaj ? s_adx : s_ady;
    y_w     = OFF_W'(y_m);
    lb_w    = signed'(OFF_W'(lb_q));
    row_off = y_w * lb_w;
    col_off = OFF_W'(x_m >>> 3);
    s_off   = row_off + col_off;
    s_mask  = MASK_RESET >> x_m[2:0];
  end

  // ---- step: emit current pixel and advance ----
  logic signed [XW-1:0] dec_sub;
  logic                 do_row, do_col, wrap;
  logic [OFF_W-1:0]     row_add;
  logic [MASK_W-1:0]    mask_sh;

  always_comb begin
    pix.byte_offset = off_q;
    pix.bit_mask    = mask_q;
    pix.last_pixel  = (rem_q == '0);

    dec_sub = dec_q - signed'(XW'(xmaj_q ? ady_q : adx_q));
    do_row  = xmaj_q ? dec_sub[XW-1] : 1'b1;
    do_col  = xmaj_q ? 1'b1 : dec_sub[XW-1];
    mask_sh = mask_q >> 1;
    wrap    = do_col && mask_q[0];
    row_add = do_row ? (up_q ? -OFF_W'(lb_q) : OFF_W'(lb_q)) : '0;

    active_d = active_q;
    off_d    = off_q;
    mask_d   = mask_q;
    dec_d    = dec_q;
    rem_d    = rem_q;
    adx_d    = adx_q;
    ady_d    = ady_q;
    xmaj_d   = xmaj_q;
    up_d     = up_q;

    if (acc && in_i.func == FUNC_START) begin
      active_d = 1'b1;
      off_d    = s_off;
      mask_d   = s_mask;
      dec_d    = signed'(XW'(s_major >> 1));
      rem_d    = s_major;
      adx_d    = s_adx;
      ady_d    = s_ady;
      xmaj_d   = s_xmaj;
      up_d     = s_up;
    end else if (push) begin
      off_d  = off_q + row_add + OFF_W'(wrap);
      mask_d = do_col ? (wrap ? MASK_RESET : mask_sh) : mask_q;
      dec_d  = dec_sub[XW-1]
             ? dec_sub + signed'(XW'(xmaj_q ? adx_q : ady_q)) : dec_sub;
      if (rem_q == '0) begin
        active_d = 1'b0;
      end else begin
        rem_d = rem_q - COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      off_q    <= '0;
      mask_q   <= MASK_RESET;
      dec_q    <= '0;
      rem_q    <= '0;
      adx_q    <= '0;
      ady_q    <= '0;
      xmaj_q   <= 1'b0;
      up_q     <= 1'b0;
    end else begin
      active_q <= active_d;
      off_q    <= off_d;
      mask_q   <= mask_d;
      dec_q    <= dec_d;
      rem_q    <= rem_d;
      adx_q    <= adx_d;
      ady_q    <= ady_d;
      xmaj_q   <= xmaj_d;
      up_q     <= up_d;
    end
  end

  // ---- output register with skid ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_q <= pix;
      end else begin
        skid_q <= pix;
      end
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.byte_offset = out_q.byte_offset;
  assign out_o.bit_mask    = out_q.bit_mask;
  assign out_o.last_pixel  = out_q.last_pixel;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without output entry");

  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mask_q))
    else $error("pixel mask not one-hot");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && rem_q == '0) |=> !active_q)
    else $error("line still active after last pixel");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_v_q)
    else $error("pixel beat lost");
`endif

endmodule
